@@ design/aopm_pkg.sv @@
// Shared types and constants for the modem receive prefix matcher.
// Used by the front end, the item queue, the back end and the top level.
package aopm_pkg;

  localparam int HANDLER_COUNT_DEF    = 4;
  localparam int MAX_PREFIX_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF      = 2;

  // Handler slots present in the register map.
  localparam int HANDLER_SLOTS = 4;

  localparam int LEN_W    = 12;
  localparam int CAP_W    = 13;
  localparam int PFX_W    = 64;
  localparam int PLEN_W   = 4;
  localparam int PLENS_W  = 16;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 64;

  localparam logic [7:0]       CH_LF     = 8'd10;
  localparam logic [7:0]       CH_CR     = 8'd13;
  localparam logic [CAP_W-1:0] CAP_LIMIT = 13'd4096;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  localparam logic [CFG_A_W-1:0] CFG_LINE_CAP  = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_PREFIX_0  = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_PREFIX_1  = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_PREFIX_2  = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_PREFIX_3  = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_PLENGTHS  = 3'd5;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_MATCH   = 2'd1,
    EV_TIMEOUT = 2'd2,
    EV_CLEARED = 2'd3
  } aopm_event_t;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_SKIP    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } aopm_kind_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    aopm_kind_t kind;
    logic [7:0] line_byte;
  } aopm_item_t;

endpackage

@@ design/aopm_front.sv @@
// Front end: accepts receive items, folds CR/LF pairs and classifies them.
// Depends on aopm_pkg for the item type and character constants.
module aopm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [7:0]         rx_byte,
  output logic               item_valid,
  input  logic               item_ready,
  output aopm_pkg::aopm_item_t item
);
  import aopm_pkg::*;

  logic [7:0] prev_r, prev_nxt;
  logic       accept;
  logic       pair_second;
  logic       is_nl;

  assign in_ready   = item_ready;
  assign item_valid = in_valid;
  assign accept     = in_valid && item_ready;

  assign pair_second = ((rx_byte == CH_CR) && (prev_r == CH_LF)) ||
                       ((rx_byte == CH_LF) && (prev_r == CH_CR));
  assign is_nl       = (rx_byte == CH_CR) || (rx_byte == CH_LF);

  always_comb begin
    prev_nxt = prev_r;
    if (func) begin
      item.kind      = KIND_TIMEOUT;
      item.line_byte = 8'd0;
    end else if (pair_second) begin
      item.kind      = KIND_SKIP;
      item.line_byte = 8'd0;
    end else begin
      item.kind      = KIND_APPEND;
      item.line_byte = is_nl ? CH_LF : rx_byte;
    end
    // A timeout leaves the remembered raw byte alone.
    if (accept && !func) begin
      prev_nxt = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 8'd0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

@@ design/aopm_queue.sv @@
// Short queue of classified items between the front end and the back end.
// Depends on aopm_pkg for the item type.
module aopm_queue #(
  parameter int DEPTH = aopm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  aopm_pkg::aopm_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output aopm_pkg::aopm_item_t pop_item
);
  import aopm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  aopm_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ design/aopm_back.sv @@
// Back end: holds the line state and configuration, matches handler prefixes
// and registers the result. Depends on aopm_pkg.
module aopm_back #(
  parameter int HANDLER_COUNT    = aopm_pkg::HANDLER_COUNT_DEF,
  parameter int MAX_PREFIX_BYTES = aopm_pkg::MAX_PREFIX_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aopm_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [aopm_pkg::CFG_D_W-1:0]  cfg_wdata,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  aopm_pkg::aopm_item_t          item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_data,
  output logic [2:0]                    out_user
);
  import aopm_pkg::*;

  localparam int HW = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;
  localparam logic [LEN_W-1:0]  HEAD_LEN = LEN_W'(MAX_PREFIX_BYTES);
  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(MAX_PREFIX_BYTES);

  // Configuration registers.
  logic [CAP_W-1:0]   cap_r;
  logic [PFX_W-1:0]   prefix_r [HANDLER_SLOTS];
  logic [PLENS_W-1:0] plens_r;

  // Line state.
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       head_r [MAX_PREFIX_BYTES];
  logic [7:0]       merged [MAX_PREFIX_BYTES];

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  logic              pop;
  logic [CAP_W-1:0]  cap_sat;
  logic [CAP_W-1:0]  len_inc;
  logic [CAP_W-1:0]  len_inc2;
  logic [HANDLER_SLOTS-1:0] hit;
  logic              any_hit;
  logic [1:0]        hit_idx;
  logic [PLEN_W-1:0] plen;
  logic              bytes_ok;
  aopm_event_t       ev;
  logic [1:0]        hidx;
  logic              lbv;
  logic [7:0]        lbyte;

  assign item_ready = !out_valid_r || out_ready;
  assign pop        = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_user   = out_user_r;

  assign cap_sat  = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;
  assign len_inc  = {1'b0, len_r} + CAP_W'(1);
  assign len_inc2 = len_inc + CAP_W'(1);

  // Head bytes as they stand once the incoming byte is written.
  always_comb begin
    for (int b = 0; b < MAX_PREFIX_BYTES; b++) begin
      merged[b] = (len_r == LEN_W'(b)) ? item.line_byte : head_r[b];
    end
  end

  always_comb begin
    hit = '0;
    for (int k = 0; k < HANDLER_SLOTS; k++) begin
      plen     = plens_r[PLEN_W*k +: PLEN_W];
      bytes_ok = 1'b1;
      for (int b = 0; b < MAX_PREFIX_BYTES; b++) begin
        if ((PLEN_W'(b) < plen) && (merged[b] != prefix_r[k][8*b +: 8])) begin
          bytes_ok = 1'b0;
        end
      end
      if ((k < HANDLER_COUNT) && (plen != '0) && (plen <= PLEN_MAX) &&
          (len_inc == CAP_W'(plen)) && bytes_ok) begin
        hit[k] = 1'b1;
      end
    end
  end

  // Lowest matching handler wins.
  always_comb begin
    any_hit = 1'b0;
    hit_idx = 2'd0;
    for (int k = HANDLER_SLOTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        any_hit = 1'b1;
        hit_idx = 2'(k);
      end
    end
  end

  always_comb begin
    len_nxt = len_r;
    ev      = EV_NONE;
    hidx    = 2'd0;
    lbv     = 1'b0;
    lbyte   = 8'd0;
    case (item.kind)
      KIND_TIMEOUT: begin
        ev      = EV_TIMEOUT;
        len_nxt = '0;
      end
      KIND_APPEND: begin
        lbv   = 1'b1;
        lbyte = item.line_byte;
        if (any_hit) begin
          ev      = EV_MATCH;
          hidx    = hit_idx;
          len_nxt = '0;
        end else if ((len_inc2 >= cap_sat) || (item.line_byte == CH_LF)) begin
          ev      = EV_CLEARED;
          len_nxt = '0;
        end else begin
          len_nxt = len_inc[LEN_W-1:0];
        end
      end
      default: begin
      end
    endcase
    if (!pop) begin
      len_nxt = len_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0, lbyte, hidx};
      out_user_nxt  = {lbv, ev};
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      plens_r     <= '0;
      for (int k = 0; k < HANDLER_SLOTS; k++) begin
        prefix_r[k] <= '0;
      end
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LINE_CAP: cap_r       <= cfg_wdata[CAP_W-1:0];
          CFG_PREFIX_0: prefix_r[0] <= cfg_wdata;
          CFG_PREFIX_1: prefix_r[1] <= cfg_wdata;
          CFG_PREFIX_2: prefix_r[2] <= cfg_wdata;
          CFG_PREFIX_3: prefix_r[3] <= cfg_wdata;
          CFG_PLENGTHS: plens_r     <= cfg_wdata[PLENS_W-1:0];
          default: begin
          end
        endcase
      end
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    if (pop && (item.kind == KIND_APPEND) && (len_r < HEAD_LEN)) begin
      head_r[len_r[HW-1:0]] <= item.line_byte;
    end
  end

endmodule

@@ design/at_oob_prefix_matcher_top.sv @@
// Modem receive prefix matcher: top level wiring front end, queue and back end.
// An accepted item is written into the queue memory, then into the back end's result register.
// Throughput: one item per cycle; the back end retires one queued item each cycle unless its result is stalled.
// Reset (rst_n low, synchronous) empties the queue, clears the line and the
// remembered raw byte and restores the register defaults; no clearing pass.
module at_oob_prefix_matcher_top #(
  parameter int HANDLER_COUNT    = aopm_pkg::HANDLER_COUNT_DEF,
  parameter int MAX_PREFIX_BYTES = aopm_pkg::MAX_PREFIX_BYTES_DEF,
  parameter int QUEUE_DEPTH      = aopm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aopm_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [aopm_pkg::CFG_D_W-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // rx_byte [7:0]
  input  logic                          in_tuser,   // func [0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // handler_index [1:0], line_byte [9:2]
  output logic [2:0]                    out_tuser   // event_res [1:0], line_byte_valid [2]
);
  import aopm_pkg::*;

  logic       fe_valid, fe_ready;
  aopm_item_t fe_item;
  logic       be_valid, be_ready;
  aopm_item_t be_item;

  aopm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (in_tuser),
    .rx_byte    (in_tdata),
    .item_valid (fe_valid),
    .item_ready (fe_ready),
    .item       (fe_item)
  );

  aopm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_item  (fe_item),
    .pop_valid  (be_valid),
    .pop_ready  (be_ready),
    .pop_item   (be_item)
  );

  aopm_back #(
    .HANDLER_COUNT    (HANDLER_COUNT),
    .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item_valid (be_valid),
    .item_ready (be_ready),
    .item       (be_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_user   (out_tuser)
  );

endmodule
